/* rtl/fpba_pkg.sv */
package fpba_pkg;

  // defaults for the top-level parameters
  localparam int unsigned MAX_BLOCKS_DEF = 16;
  localparam int unsigned SIZE_BITS_DEF  = 16;

  // fixed port widths
  localparam int unsigned SLOT_W     = 4;
  localparam int unsigned SIZE_IN_W  = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 5;
  localparam int unsigned MODE_W     = 2;

  // request types
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_ALLOC = 1'b1;

  // fit policies; the unused code behaves as first fit
  localparam logic [MODE_W-1:0] FIT_FIRST = 2'd0;
  localparam logic [MODE_W-1:0] FIT_BEST  = 2'd1;
  localparam logic [MODE_W-1:0] FIT_WORST = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FIT_MODE      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCKS_IN_USE = 2'd1;

  localparam logic [MODE_W-1:0]     FIT_MODE_RST      = FIT_FIRST;
  localparam logic [CFG_DATA_W-1:0] BLOCKS_IN_USE_RST = 5'd16;

endpackage

/* rtl/fit_policy_block_allocator.sv */
// Channel  | Direction | Handshake              | Word
// ---------+-----------+------------------------+------------------------------------------
// in       | input     | in_valid_i/in_stall_o  | req_type, block_slot, size_value
// out      | output    | out_valid_o/out_stall_i| granted, chosen_block, remaining_size
// cfg      | input     | cfg_valid_i/cfg_ready_o| cfg_index_i, cfg_data_i
//
// One word is in flight at a time. A load goes straight to the write-back state, where
// its result word is registered once the output register is free; an allocate first
// scans min(blocks_in_use, MAX_BLOCKS) blocks through the free-size table's single read
// port, which delivers one block per cycle to the compare stage. The input reopens as
// the result is registered, so a new word is not taken before the last one is through.
// Reset clears the control state and registers; the free-size table is not cleared,
// so a block must be loaded before an allocate scans it.
// A stalled output holds its word; the next input word is still taken and waits
// in the write-back state until the output register frees up.
module fit_policy_block_allocator
  import fpba_pkg::*;
#(
  parameter int unsigned MAX_BLOCKS = MAX_BLOCKS_DEF,
  parameter int unsigned SIZE_BITS  = SIZE_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // input words
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  req_type_i,
  input  logic [SLOT_W-1:0]     block_slot_i,
  input  logic [SIZE_IN_W-1:0]  size_value_i,
  // result words
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  granted_o,
  output logic [SLOT_W-1:0]     chosen_block_o,
  output logic [SIZE_IN_W-1:0]  remaining_size_o,
  // configuration writes
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_BLOCKS + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

  state_e state_q;

  // configuration
  logic [MODE_W-1:0]     fit_mode_q;
  logic [CFG_DATA_W-1:0] blocks_in_use_q;

  // latched request
  logic                  req_type_q;
  logic [SLOT_W-1:0]     req_slot_q;
  logic [SIZE_BITS-1:0]  req_size_q;

  // scan control
  logic [CNT_W-1:0]      scan_cnt_q;
  logic [CNT_W-1:0]      scan_end_q;
  logic                  issue_done_q;
  logic                  rd_vld_q;
  logic [IDX_W-1:0]      rd_idx_q;
  logic [SIZE_BITS-1:0]  rd_data_q;

  // running pick
  logic                  found_q;
  logic [IDX_W-1:0]      pick_idx_q;
  logic [SIZE_BITS-1:0]  pick_val_q;

  // output register
  logic                  out_valid_q;
  logic                  granted_q;
  logic [SLOT_W-1:0]     chosen_q;
  logic [SIZE_IN_W-1:0]  remain_q;

  // free-size table
  logic [SIZE_BITS-1:0]  mem_q [MAX_BLOCKS];
  logic                  mem_we;
  logic [IDX_W-1:0]      mem_wa;
  logic [SIZE_BITS-1:0]  mem_wd;
  logic                  mem_re;

  logic                  in_acc;
  logic                  out_free;
  logic                  load_ok;
  logic                  fit_take;
  logic [SIZE_BITS-1:0]  rem_alloc;
  logic [CNT_W-1:0]      scan_cnt_inc;
  logic [CNT_W-1:0]      count_sat;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign cfg_ready_o = 1'b1;

  // blocks in use, saturated to the table depth
  always_comb begin
    if (32'(blocks_in_use_q) > MAX_BLOCKS) begin
      count_sat = CNT_W'(MAX_BLOCKS);
    end else begin
      count_sat = CNT_W'(blocks_in_use_q);
    end
  end

  assign load_ok      = (32'(req_slot_q) < MAX_BLOCKS);
  assign rem_alloc    = pick_val_q - req_size_q;
  assign scan_cnt_inc = CNT_W'(scan_cnt_q + 1'b1);

  // compare stage: does the block just read replace the current pick
  always_comb begin
    fit_take = 1'b0;
    if (rd_vld_q && (rd_data_q >= req_size_q)) begin
      if (!found_q) begin
        fit_take = 1'b1;
      end else if (fit_mode_q == FIT_BEST) begin
        fit_take = (rd_data_q < pick_val_q);
      end else if (fit_mode_q == FIT_WORST) begin
        fit_take = (rd_data_q > pick_val_q);
      end
    end
  end

  // table access: reads during the scan, at most one write-back at the end
  assign mem_re = (state_q == ST_SCAN) && !issue_done_q;
  assign mem_we = (state_q == ST_DONE) && out_free &&
                  ((req_type_q == REQ_ALLOC) ? found_q : load_ok);
  assign mem_wa = (req_type_q == REQ_ALLOC) ? pick_idx_q : IDX_W'(req_slot_q);
  assign mem_wd = (req_type_q == REQ_ALLOC) ? rem_alloc : req_size_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data_q <= mem_q[scan_cnt_q[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IDLE;
      fit_mode_q      <= FIT_MODE_RST;
      blocks_in_use_q <= BLOCKS_IN_USE_RST;
      req_type_q      <= REQ_LOAD;
      req_slot_q      <= '0;
      req_size_q      <= '0;
      scan_cnt_q      <= '0;
      scan_end_q      <= '0;
      issue_done_q    <= 1'b0;
      rd_vld_q        <= 1'b0;
      rd_idx_q        <= '0;
      found_q         <= 1'b0;
      pick_idx_q      <= '0;
      pick_val_q      <= '0;
      out_valid_q     <= 1'b0;
      granted_q       <= 1'b0;
      chosen_q        <= '0;
      remain_q        <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CFG_FIT_MODE) begin
          fit_mode_q <= cfg_data_i[MODE_W-1:0];
        end else if (cfg_index_i == CFG_BLOCKS_IN_USE) begin
          blocks_in_use_q <= cfg_data_i;
        end
      end

      // in the write-back state the output register is reloaded instead
      if (out_valid_q && !out_stall_i && (state_q != ST_DONE)) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            req_type_q <= req_type_i;
            req_slot_q <= block_slot_i;
            req_size_q <= SIZE_BITS'(size_value_i);
            if (req_type_i == REQ_ALLOC) begin
              scan_cnt_q   <= '0;
              scan_end_q   <= count_sat;
              issue_done_q <= (count_sat == '0);
              rd_vld_q     <= 1'b0;
              found_q      <= 1'b0;
              state_q      <= ST_SCAN;
            end else begin
              state_q <= ST_DONE;
            end
          end
        end
        ST_SCAN: begin
          // issue stage
          rd_vld_q <= !issue_done_q;
          rd_idx_q <= scan_cnt_q[IDX_W-1:0];
          if (!issue_done_q) begin
            scan_cnt_q   <= scan_cnt_inc;
            issue_done_q <= (scan_cnt_inc == scan_end_q);
          end
          // compare stage
          if (fit_take) begin
            found_q    <= 1'b1;
            pick_idx_q <= rd_idx_q;
            pick_val_q <= rd_data_q;
          end
          if (issue_done_q && !rd_vld_q) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
            if (req_type_q == REQ_ALLOC) begin
              granted_q <= found_q;
              chosen_q  <= found_q ? SLOT_W'(pick_idx_q) : '0;
              remain_q  <= found_q ? SIZE_IN_W'(rem_alloc) : '0;
            end else begin
              granted_q <= load_ok;
              chosen_q  <= load_ok ? req_slot_q : '0;
              remain_q  <= load_ok ? SIZE_IN_W'(req_size_q) : '0;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o      = out_valid_q;
  assign granted_o        = granted_q;
  assign chosen_block_o   = chosen_q;
  assign remaining_size_o = remain_q;

  // one word at a time: an accepted word closes the input
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> in_stall_o)
    else $error("input accepted while a word is in flight");

  // a refused word carries no block and no size
  a_no_grant_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !granted_o) |-> (chosen_block_o == '0 && remaining_size_o == '0))
    else $error("refused word carries data");

  // reads never run past the blocks in use
  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && rd_vld_q) |-> (CNT_W'(rd_idx_q) < scan_end_q))
    else $error("scan read beyond blocks in use");

  // the running pick always fits the request
  a_pick_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && found_q) |-> (pick_val_q >= req_size_q))
    else $error("pick smaller than request");

endmodule
